FILE: rtl/core/dph_pkg.sv
// ============================================================================
// dph_pkg
// Shared constants and fold tables for the double polynomial string hash.
// ============================================================================
package dph_pkg;

    // Moduli of the two hash lanes
    localparam logic [29:0] MOD_ONE = 30'd1000000007;
    localparam logic [29:0] MOD_TWO = 30'd1000000009;

    // Register reset values
    localparam logic [15:0] BASE_ONE_RESET = 16'd137;
    localparam logic [15:0] BASE_TWO_RESET = 16'd277;

    // Configuration register indexes
    localparam logic [1:0] REG_BASE_ONE = 2'd0;
    localparam logic [1:0] REG_BASE_TWO = 2'd1;

    // Lane codes
    localparam logic LANE_ONE = 1'b0;
    localparam logic LANE_TWO = 1'b1;

    typedef logic [29:0] fold_tab_t [256];

    // Entry i holds (i << shift) mod M of the chosen lane; evaluated at elaboration.
    function automatic fold_tab_t build_fold(input logic lane, input int unsigned shift);
        fold_tab_t   tab;
        logic [63:0] val;
        for (int i = 0; i < 256; i++)
        begin
            val = 64'(i) << shift;
            if (lane == LANE_TWO)
            begin
                tab[i] = 30'(val % 64'(MOD_TWO));
            end
            else
            begin
                tab[i] = 30'(val % 64'(MOD_ONE));
            end
        end
        return tab;
    endfunction

    localparam fold_tab_t FOLD30_ONE = build_fold(LANE_ONE, 30);
    localparam fold_tab_t FOLD38_ONE = build_fold(LANE_ONE, 38);
    localparam fold_tab_t FOLD30_TWO = build_fold(LANE_TWO, 30);
    localparam fold_tab_t FOLD38_TWO = build_fold(LANE_TWO, 38);

endpackage

FILE: rtl/core/dph_mulmod.sv
// ============================================================================
// dph_mulmod
// Combinational modular multiply: 30-bit operand by 16-bit operand, reduced
// modulo the lane's prime by byte-indexed fold tables and a final subtract.
// ============================================================================
module dph_mulmod
(
    input  logic        lane,
    input  logic [29:0] a,
    input  logic [15:0] b,
    output logic [29:0] r
);

    logic [45:0] prod;
    logic [29:0] fold_lo;
    logic [29:0] fold_hi;
    logic [31:0] fsum;
    logic [31:0] mod_x1;
    logic [31:0] mod_x2;
    logic [31:0] mod_x3;
    logic [31:0] sub;

    assign prod = 46'(a) * 46'(b);

    // prod = hi * 2^38 + mid * 2^30 + lo; upper bytes fold through tables
    always_comb
    begin
        if (lane == dph_pkg::LANE_TWO)
        begin
            fold_lo = dph_pkg::FOLD30_TWO[prod[37:30]];
            fold_hi = dph_pkg::FOLD38_TWO[prod[45:38]];
            mod_x1  = 32'(dph_pkg::MOD_TWO);
        end
        else
        begin
            fold_lo = dph_pkg::FOLD30_ONE[prod[37:30]];
            fold_hi = dph_pkg::FOLD38_ONE[prod[45:38]];
            mod_x1  = 32'(dph_pkg::MOD_ONE);
        end
    end

    assign mod_x2 = mod_x1 << 1;
    assign mod_x3 = mod_x2 + mod_x1;

    // fsum < 2^30 + 2M, i.e. below 4M
    assign fsum = 32'(prod[29:0]) + 32'(fold_lo) + 32'(fold_hi);

    always_comb
    begin
        if (fsum >= mod_x3)
        begin
            sub = mod_x3;
        end
        else if (fsum >= mod_x2)
        begin
            sub = mod_x2;
        end
        else if (fsum >= mod_x1)
        begin
            sub = mod_x1;
        end
        else
        begin
            sub = 32'd0;
        end
    end

    assign r = 30'(fsum - sub);

endmodule

FILE: rtl/core/double_polynomial_string_hash_top.sv
// Result path: a last byte's terms are registered in the term stage, then its hashes and
// out_valid in the result registers; the power update (multiply plus fold) is combinational.
// Throughput: one byte per cycle while in_stall is low. A last byte waiting on a stalled
// result holds the input off until the result drains.
// Reset (rst_n low, asynchronous): bases 137 / 277, sums 0, powers 1, pipe empty.
// ============================================================================
// double_polynomial_string_hash_top
// Double polynomial rolling hash mod 1000000007 and mod 1000000009 over a
// byte stream; one result transaction per string on the last byte.
// ============================================================================
module double_polynomial_string_hash_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [29:0] hash_one,
    output logic [29:0] hash_two
);

    logic [15:0] base_one_reg;
    logic [15:0] base_two_reg;
    logic [29:0] power_one_reg;
    logic [29:0] power_two_reg;
    logic [29:0] power_one_next;
    logic [29:0] power_two_next;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_last_reg;
    logic [29:0] term_one_reg;
    logic [29:0] term_two_reg;
    logic [29:0] sum_one_reg;
    logic [29:0] sum_two_reg;
    logic [29:0] sum_one_next;
    logic [29:0] sum_two_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [29:0] hash_one_reg;
    logic [29:0] hash_two_reg;

    logic [29:0] pow_mul_one;
    logic [29:0] pow_mul_two;
    logic [29:0] term_one;
    logic [29:0] term_two;
    logic [30:0] add_one;
    logic [30:0] add_two;
    logic [29:0] acc_one;
    logic [29:0] acc_two;
    logic        in_acc;
    logic        out_free;
    logic        s1_move;

    dph_mulmod u_pow_one
    (
        .lane (dph_pkg::LANE_ONE),
        .a    (power_one_reg),
        .b    (base_one_reg),
        .r    (pow_mul_one)
    );

    dph_mulmod u_pow_two
    (
        .lane (dph_pkg::LANE_TWO),
        .a    (power_two_reg),
        .b    (base_two_reg),
        .r    (pow_mul_two)
    );

    dph_mulmod u_term_one
    (
        .lane (dph_pkg::LANE_ONE),
        .a    (power_one_reg),
        .b    ({8'd0, char_code}),
        .r    (term_one)
    );

    dph_mulmod u_term_two
    (
        .lane (dph_pkg::LANE_TWO),
        .a    (power_two_reg),
        .b    ({8'd0, char_code}),
        .r    (term_two)
    );

    // Pipe control: term stage only waits on the output when it holds a last byte
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_acc   = in_valid && !in_stall;

    // Running sums, modular add
    assign add_one = 31'(sum_one_reg) + 31'(term_one_reg);
    assign add_two = 31'(sum_two_reg) + 31'(term_two_reg);
    assign acc_one = (add_one >= 31'(dph_pkg::MOD_ONE)) ?
                     30'(add_one - 31'(dph_pkg::MOD_ONE)) : add_one[29:0];
    assign acc_two = (add_two >= 31'(dph_pkg::MOD_TWO)) ?
                     30'(add_two - 31'(dph_pkg::MOD_TWO)) : add_two[29:0];

    always_comb
    begin
        power_one_next = power_one_reg;
        power_two_next = power_two_reg;
        if (in_acc)
        begin
            if (last_char)
            begin
                power_one_next = 30'd1;
                power_two_next = 30'd1;
            end
            else
            begin
                power_one_next = pow_mul_one;
                power_two_next = pow_mul_two;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        sum_one_next = sum_one_reg;
        sum_two_next = sum_two_reg;
        if (s1_move)
        begin
            if (s1_last_reg)
            begin
                sum_one_next = 30'd0;
                sum_two_next = 30'd0;
            end
            else
            begin
                sum_one_next = acc_one;
                sum_two_next = acc_two;
            end
        end
    end

    always_comb
    begin
        if (s1_move && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_one_reg  <= dph_pkg::BASE_ONE_RESET;
            base_two_reg  <= dph_pkg::BASE_TWO_RESET;
            power_one_reg <= 30'd1;
            power_two_reg <= 30'd1;
            sum_one_reg   <= 30'd0;
            sum_two_reg   <= 30'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    dph_pkg::REG_BASE_ONE: base_one_reg <= cfg_data;
                    dph_pkg::REG_BASE_TWO: base_two_reg <= cfg_data;
                    default: ;
                endcase
            end
            power_one_reg <= power_one_next;
            power_two_reg <= power_two_next;
            sum_one_reg   <= sum_one_next;
            sum_two_reg   <= sum_two_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_last_reg  <= last_char;
            term_one_reg <= term_one;
            term_two_reg <= term_two;
        end
        if (s1_move && s1_last_reg)
        begin
            hash_one_reg <= acc_one;
            hash_two_reg <= acc_two;
        end
    end

    assign out_valid = out_valid_reg;
    assign hash_one  = hash_one_reg;
    assign hash_two  = hash_two_reg;

    // A last byte restarts both power chains
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && last_char |=> power_one_reg == 30'd1 && power_two_reg == 30'd1)
        else $error("power not restarted after last byte");

    // Running sums stay reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        sum_one_reg < dph_pkg::MOD_ONE && sum_two_reg < dph_pkg::MOD_TWO)
        else $error("running sum out of range");

    // A new result only follows a last byte leaving the term stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result without last byte");

    // Delivered hashes are reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> hash_one_reg < dph_pkg::MOD_ONE && hash_two_reg < dph_pkg::MOD_TWO)
        else $error("hash out of range");

endmodule
